@@ hdl/mhfb_pkg.sv @@
// shared types, constants and crc helpers for the multicast hash filter builder
// no dependencies; imported by every module of the block
`default_nettype none

package mhfb_pkg;

  localparam int unsigned AddrW   = 48;
  localparam int unsigned FilterW = 64;
  localparam int unsigned WordW   = 32;
  localparam int unsigned HashW   = 6;
  localparam int unsigned InDataW  = 96;
  localparam int unsigned OutDataW = 72;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  localparam logic [31:0] CrcPoly = 32'h04C11DB7;
  localparam logic [31:0] CrcSeed = 32'hFFFFFFFF;
  localparam logic [4:0]  BitFlip = 5'd24;

  localparam logic CmdBegin = 1'b0;
  localparam logic CmdAdd   = 1'b1;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_FILL,
    OP_RANGE,
    OP_HASH
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [HashW-1:0] hash;
  } entry_t;

  // bit-serial crc, only evaluated on constants
  function automatic logic [31:0] crc_raw(input logic [31:0] seed,
                                          input logic [AddrW-1:0] data);
    logic [31:0] crc;
    logic        fb;
    crc = seed;
    for (int i = 0; i < AddrW; i++) begin
      fb  = crc[31] ^ data[i];
      crc = {crc[30:0], 1'b0};
      if (fb) begin
        crc = crc ^ CrcPoly;
      end
    end
    return crc;
  endfunction

  function automatic logic [AddrW-1:0][31:0] crc_cols();
    logic [AddrW-1:0][31:0] cols;
    for (int i = 0; i < AddrW; i++) begin
      cols[i] = crc_raw(32'h0, AddrW'(1) << i);
    end
    return cols;
  endfunction

  localparam logic [31:0]            CrcBase = crc_raw(CrcSeed, '0);
  localparam logic [AddrW-1:0][31:0] CrcCols = crc_cols();

endpackage

`default_nettype wire

@@ hdl/mhfb_front.sv @@
// front end: takes input words, hashes the address and classifies the command
// depends on mhfb_pkg; feeds mhfb_queue
`default_nettype none

module mhfb_front (
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [mhfb_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  wire logic                          s_axis_tuser_i,
  input  wire logic                          promisc_i,
  input  wire logic                          q_full_i,
  output logic                               push_o,
  output mhfb_pkg::entry_t                   entry_o
);
  import mhfb_pkg::*;

  logic [AddrW-1:0] addr_lo;
  logic [AddrW-1:0] addr_hi;
  logic [31:0]      crc;

  assign addr_lo = s_axis_tdata_i[AddrW-1:0];
  assign addr_hi = s_axis_tdata_i[2*AddrW-1:AddrW];

  // crc is linear: seed term xor one column per set address bit
  always_comb begin
    crc = CrcBase;
    for (int i = 0; i < AddrW; i++) begin
      if (addr_lo[i]) begin
        crc = crc ^ CrcCols[i];
      end
    end
  end

  always_comb begin
    entry_o.hash = crc[31:32-HashW];
    if (s_axis_tuser_i == CmdBegin) begin
      entry_o.op = promisc_i ? OP_FILL : OP_CLEAR;
    end else if (addr_lo != addr_hi) begin
      entry_o.op = OP_RANGE;
    end else begin
      entry_o.op = OP_HASH;
    end
  end

  assign s_axis_tready_o = !q_full_i;
  assign push_o          = s_axis_tvalid_i && !q_full_i;

endmodule

`default_nettype wire

@@ hdl/mhfb_queue.sv @@
// short fifo of classified commands between front and back
// depends on mhfb_pkg
`default_nettype none

module mhfb_queue (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  mhfb_pkg::entry_t entry_i,
  output logic             full_o,
  output logic             valid_o,
  output mhfb_pkg::entry_t entry_o,
  input  wire logic        pop_i
);
  import mhfb_pkg::*;

  entry_t             mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

@@ hdl/mhfb_back.sv @@
// back end: applies commands to the filter state and holds the result word
// depends on mhfb_pkg; fed by mhfb_queue
`default_nettype none

module mhfb_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          q_valid_i,
  input  mhfb_pkg::entry_t                   entry_i,
  output logic                               pop_o,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic [mhfb_pkg::OutDataW-1:0]      m_axis_tdata_o
);
  import mhfb_pkg::*;

  logic [FilterW-1:0] filter_q, filter_d;
  logic               flag_q, flag_d;
  logic [HashW-1:0]   hash_q, hash_d;
  logic               out_valid_q, out_valid_d;
  logic [HashW-1:0]   bit_pos;

  assign pop_o   = q_valid_i && (!out_valid_q || m_axis_tready_i);
  assign bit_pos = {entry_i.hash[HashW-1], entry_i.hash[HashW-2:0] ^ BitFlip};

  always_comb begin
    filter_d = filter_q;
    flag_d   = flag_q;
    hash_d   = '0;
    case (entry_i.op)
      OP_CLEAR: begin
        filter_d = '0;
        flag_d   = 1'b0;
      end
      OP_FILL: begin
        filter_d = '1;
        flag_d   = 1'b1;
      end
      OP_RANGE: begin
        if (!flag_q) begin
          filter_d = '1;
          flag_d   = 1'b1;
        end
      end
      OP_HASH: begin
        if (!flag_q) begin
          filter_d = filter_q | (FilterW'(1) << bit_pos);
          hash_d   = entry_i.hash;
        end
      end
      default: begin
        filter_d = filter_q;
      end
    endcase
  end

  always_comb begin
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_q    <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        filter_q <= filter_d;
        flag_q   <= flag_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      hash_q <= hash_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, hash_q, flag_q, filter_q[FilterW-1:WordW],
                            filter_q[WordW-1:0]};

endmodule

`default_nettype wire

@@ hdl/multicast_hash_filter_builder.sv @@
// an input handshake reaches the earliest result handshake through the queue
// write, then the result register
// throughput: one word per cycle; a 4-entry command queue absorbs output stalls
// input ready drops only when that queue is full
// reset (rst_ni low, asynchronous) clears the filter, the all-multicast flag,
// the promiscuous register and the queue
`default_nettype none

module multicast_hash_filter_builder (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_wdata_i,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // address_low [47:0], address_high [95:48]
  input  wire logic [mhfb_pkg::InDataW-1:0]  s_axis_tdata_i,
  // cmd
  input  wire logic                          s_axis_tuser_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // filter_low_word [31:0], filter_high_word [63:32], all_multicast [64],
  // hash_index [70:65], zero [71]
  output logic [mhfb_pkg::OutDataW-1:0]      m_axis_tdata_o
);
  import mhfb_pkg::*;

  logic   promisc_q;
  logic   push;
  logic   q_full;
  logic   q_valid;
  logic   pop;
  entry_t push_entry;
  entry_t head_entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      promisc_q <= 1'b0;
    end else if (cfg_we_i) begin
      promisc_q <= cfg_wdata_i;
    end
  end

  mhfb_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .promisc_i       (promisc_q),
    .q_full_i        (q_full),
    .push_o          (push),
    .entry_o         (push_entry)
  );

  mhfb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .entry_o (head_entry),
    .pop_i   (pop)
  );

  mhfb_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .entry_i         (head_entry),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

@@ hdl/mhfb_checker.sv @@
// port-level checks for the multicast hash filter builder
// depends on mhfb_pkg; bound to multicast_hash_filter_builder below
`default_nettype none

module mhfb_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  input  wire logic                          s_axis_tready_o,
  input  wire logic                          m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  input  wire logic [mhfb_pkg::OutDataW-1:0] m_axis_tdata_o
);
  import mhfb_pkg::*;

  logic             out_flag;
  logic [HashW-1:0] out_hash;
  logic [HashW-1:0] out_pos;
  logic             in_acc;

  assign out_flag = m_axis_tdata_o[FilterW];
  assign out_hash = m_axis_tdata_o[FilterW+HashW:FilterW+1];
  assign out_pos  = {out_hash[HashW-1], out_hash[HashW-2:0] ^ BitFlip};
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;

  // a result word waits unchanged while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed while stalled");

  // accept-all means every filter bit is set
  a_flag_ones: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_flag |-> m_axis_tdata_o[FilterW-1:0] == '1)
    else $error("all_multicast without a full filter");

  // a reported hash has its bit set and never comes with accept-all
  a_hash_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_hash != '0 |->
      m_axis_tdata_o[out_pos] && !out_flag)
    else $error("hash index without matching filter bit");

  // with the output empty, an accepted word brings a valid result word after the queue write and the result register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !m_axis_tvalid_o |=> ##1 m_axis_tvalid_o)
    else $error("result word late");

  // spare top bit stays zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !m_axis_tdata_o[OutDataW-1])
    else $error("padding bit set");

endmodule

bind multicast_hash_filter_builder mhfb_checker u_mhfb_checker (.*);

`default_nettype wire
